// ----- design/optd_pkg.sv -----
// Shared codes and cell control type for the ordered pair table.
package optd_pkg;

  // Operation codes carried on the opcode field
  typedef enum logic [1:0] {
    OP_ADD        = 2'd0,
    OP_REMOVE_AT  = 2'd1,
    OP_REMOVE_KEY = 2'd2,
    OP_READ_AT    = 2'd3
  } op_e;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_DUP   = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // Broadcast control for every cell of the chain
  typedef struct packed {
    logic mark_set;    // load the delete mark from the cell's hit input
    logic shift_step;  // cells at or above the lowest mark take their upper neighbour
  } cell_ctrl_t;

endpackage

// ----- design/ordered_pair_table_dedup_top.sv -----
// Top level of the ordered key/value table with duplicate rejection.
// Ordered key/value table, insertion order kept, up to CAPACITY entries.
// Input channel (in_valid_i/in_ready_o) takes one operation: add, remove at
// position, remove by key or read at position. Output channel
// (out_valid_o/out_ready_i) returns one result per operation: status, the
// pair read, the entry count afterwards and the number of entries removed.
// One operation is in progress at a time. Add and read pass through the
// steps transfer, evaluate and write result. Remove at and remove by key
// also pass through the shift stage (remove at only for a position in range);
// remove by key with duplicates allowed stays there while marks remain,
// as the cell row closes one gap per cycle.
// in_ready_o returns in the cycle the result appears.
// The output register holds a result until taken; a new operation may be
// accepted while it waits, and completes into the register once it frees.
// cfg_we_i/cfg_data_i write allow_duplicates; write only while idle.
// Reset empties the table and clears allow_duplicates; stored pairs are not
// cleared, entries at or above the fill level are never read.
module ordered_pair_table_dedup_top import optd_pkg::*; #(
  parameter int CAPACITY    = 32,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] key_in_i,
  input  logic [31:0] value_in_i,
  input  logic [7:0]  position_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] key_out_o,
  output logic [31:0] value_out_o,
  output logic [5:0]  entry_count_o,
  output logic [5:0]  removed_count_o
);

  localparam int FW  = $clog2(CAPACITY + 1);
  localparam int PCW = (FW > 8) ? FW : 8;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MARK  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]             state_q, state_d;
  logic                   allow_q;
  op_e                    op_q;
  logic [KEY_WIDTH-1:0]   key_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic [7:0]             pos_q;
  logic [FW-1:0]          fill_q, fill_d;
  logic [FW-1:0]          removed_q, removed_d;
  logic [1:0]             res_status_q, res_status_d;
  logic [KEY_WIDTH-1:0]   res_key_q, res_key_d;
  logic [VALUE_WIDTH-1:0] res_val_q, res_val_d;

  logic                   out_valid_q;
  logic [1:0]             out_status_q;
  logic [31:0]            out_key_q, out_val_q;
  logic [5:0]             out_count_q, out_removed_q;

  cell_ctrl_t             ctrl;
  logic                   in_xfer, out_free;

  // cell row wiring
  logic [KEY_WIDTH-1:0]   ckey  [CAPACITY];
  logic [VALUE_WIDTH-1:0] cval  [CAPACITY];
  logic [CAPACITY-1:0]    cmark, ckey_eq, cpair_eq, cvalid, csel, cload, chit;
  logic [CAPACITY:0]      gap;

  logic                   full, dup, pos_ok, any_mark, add_ok;
  logic [KEY_WIDTH-1:0]   rd_key;
  logic [VALUE_WIDTH-1:0] rd_val;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allow_q <= 1'b0;
    end else if (cfg_we_i) begin
      allow_q <= cfg_data_i;
    end
  end

  // operand capture on input transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q  <= op_e'(opcode_i);
      key_q <= KEY_WIDTH'(key_in_i);
      val_q <= VALUE_WIDTH'(value_in_i);
      pos_q <= position_i;
    end
  end

  // per-cell status from fill level and position
  assign gap[0] = 1'b0;
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cvalid[i] = (fill_q > FW'(i));
      csel[i]   = (pos_q == 8'(i));
      cload[i]  = add_ok && (fill_q == FW'(i));
      case (op_q)
        OP_REMOVE_KEY: chit[i] = cvalid[i] && ckey_eq[i];
        OP_REMOVE_AT:  chit[i] = pos_ok && csel[i];
        default:       chit[i] = 1'b0;
      endcase
    end
  end

  // the cell chain
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [KEY_WIDTH-1:0]   nb_key;
    logic [VALUE_WIDTH-1:0] nb_val;
    logic                   nb_mark;
    if (g == CAPACITY - 1) begin : g_end
      assign nb_key  = '0;
      assign nb_val  = '0;
      assign nb_mark = 1'b0;
    end else begin : g_mid
      assign nb_key  = ckey[g+1];
      assign nb_val  = cval[g+1];
      assign nb_mark = cmark[g+1];
    end
    optd_cell #(
      .KEY_WIDTH  (KEY_WIDTH),
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .load_i   (cload[g]),
      .hit_i    (chit[g]),
      .key_new_i(key_q),
      .val_new_i(val_q),
      .nb_key_i (nb_key),
      .nb_val_i (nb_val),
      .nb_mark_i(nb_mark),
      .gap_i    (gap[g]),
      .gap_o    (gap[g+1]),
      .key_o    (ckey[g]),
      .val_o    (cval[g]),
      .mark_o   (cmark[g]),
      .key_eq_o (ckey_eq[g]),
      .pair_eq_o(cpair_eq[g])
    );
  end

  // read bus: the selected cell drives an OR bus
  always_comb begin
    rd_key = '0;
    rd_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (csel[i]) begin
        rd_key = rd_key | ckey[i];
        rd_val = rd_val | cval[i];
      end
    end
  end

  assign full     = (fill_q == FW'(CAPACITY));
  assign dup      = !allow_q && |(cpair_eq & cvalid);
  assign pos_ok   = (PCW'(pos_q) < PCW'(fill_q));
  assign any_mark = |cmark;
  assign add_ok   = (state_q == S_MARK) && (op_q == OP_ADD) && !full && !dup;

  // sequencer
  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    removed_d    = removed_q;
    res_status_d = res_status_q;
    res_key_d    = res_key_q;
    res_val_d    = res_val_q;
    ctrl         = '0;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) state_d = S_MARK;
      end
      S_MARK: begin
        ctrl.mark_set = 1'b1;
        removed_d     = '0;
        res_status_d  = ST_OK;
        res_key_d     = '0;
        res_val_d     = '0;
        state_d       = S_FIN;
        case (op_q)
          OP_ADD: begin
            if (full) begin
              res_status_d = ST_FULL;
            end else if (dup) begin
              res_status_d = ST_DUP;
            end else begin
              fill_d = fill_q + FW'(1);
            end
          end
          OP_REMOVE_AT: begin
            if (pos_ok) state_d = S_SHIFT;
            else        res_status_d = ST_RANGE;
          end
          OP_REMOVE_KEY: begin
            state_d = S_SHIFT;
          end
          default: begin
            if (pos_ok) begin
              res_key_d = rd_key;
              res_val_d = rd_val;
            end else begin
              res_status_d = ST_RANGE;
            end
          end
        endcase
      end
      S_SHIFT: begin
        // close the lowest gap; keep going only for remove-all
        if (any_mark) begin
          ctrl.shift_step = 1'b1;
          fill_d          = fill_q - FW'(1);
          removed_d       = removed_q + FW'(1);
          if (!(op_q == OP_REMOVE_KEY && allow_q)) state_d = S_FIN;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    removed_q    <= removed_d;
    res_status_q <= res_status_d;
    res_key_q    <= res_key_d;
    res_val_q    <= res_val_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_FIN && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_FIN && out_free) begin
      out_status_q  <= res_status_q;
      out_key_q     <= 32'(res_key_q);
      out_val_q     <= 32'(res_val_q);
      out_count_q   <= 6'(fill_q);
      out_removed_q <= 6'(removed_q);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign key_out_o       = out_key_q;
  assign value_out_o     = out_val_q;
  assign entry_count_o   = out_count_q;
  assign removed_count_o = out_removed_q;

endmodule

// ----- design/optd_cell.sv -----
// One table cell: holds a key/value pair and a delete mark, shifts down on removal.
module optd_cell import optd_pkg::*; #(
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cell_ctrl_t             ctrl_i,
  input  logic                   load_i,
  input  logic                   hit_i,
  input  logic [KEY_WIDTH-1:0]   key_new_i,
  input  logic [VALUE_WIDTH-1:0] val_new_i,
  input  logic [KEY_WIDTH-1:0]   nb_key_i,
  input  logic [VALUE_WIDTH-1:0] nb_val_i,
  input  logic                   nb_mark_i,
  input  logic                   gap_i,
  output logic                   gap_o,
  output logic [KEY_WIDTH-1:0]   key_o,
  output logic [VALUE_WIDTH-1:0] val_o,
  output logic                   mark_o,
  output logic                   key_eq_o,
  output logic                   pair_eq_o
);

  logic [KEY_WIDTH-1:0]   key_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic                   mark_q;
  logic                   shift;

  // a mark here or below opens a gap that this cell must close
  assign gap_o = gap_i | mark_q;
  assign shift = ctrl_i.shift_step & gap_o;

  // pair storage: append or take the upper neighbour
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      key_q <= key_new_i;
      val_q <= val_new_i;
    end else if (shift) begin
      key_q <= nb_key_i;
      val_q <= nb_val_i;
    end
  end

  // delete mark travels with its pair
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q <= 1'b0;
    end else if (ctrl_i.mark_set) begin
      mark_q <= hit_i;
    end else if (shift) begin
      mark_q <= nb_mark_i;
    end
  end

  // local compares against the operand
  assign key_eq_o  = (key_q == key_new_i);
  assign pair_eq_o = key_eq_o && (val_q == val_new_i);

  assign key_o  = key_q;
  assign val_o  = val_q;
  assign mark_o = mark_q;

endmodule

// ----- design/optd_checker.sv -----
// Port-level checks on the ordered pair table, bound to the top level.
module optd_checker import optd_pkg::*; #(
  parameter int CAPACITY = 32
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [31:0] key_out_o,
  input logic [31:0] value_out_o,
  input logic [5:0]  entry_count_o,
  input logic [5:0]  removed_count_o
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(entry_count_o) && $stable(key_out_o))
    else $error("stalled result changed");

  // a failed operation removes nothing and returns no pair
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> removed_count_o == 6'd0
      && key_out_o == 32'd0 && value_out_o == 32'd0)
    else $error("failed operation has side results");

  // removals only come with an ok status and no read data
  a_remove_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && removed_count_o != 6'd0 |-> status_o == ST_OK
      && key_out_o == 32'd0)
    else $error("removal with bad status or read data");

  // table full is reported only at capacity
  a_full_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> entry_count_o == 6'(CAPACITY))
    else $error("full status below capacity");

endmodule

bind ordered_pair_table_dedup_top optd_checker #(.CAPACITY(CAPACITY)) u_optd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .status_o       (status_o),
  .key_out_o      (key_out_o),
  .value_out_o    (value_out_o),
  .entry_count_o  (entry_count_o),
  .removed_count_o(removed_count_o)
);
